>>> rtl/cmpl_pkg.sv
package cmpl_pkg;

  // Default build-time settings.
  localparam int PWM_MAX_DEF         = 800;
  localparam int PWM_MIN_DEF         = 0;
  localparam int POSITION_PERIOD_DEF = 1000;
  localparam int VELOCITY_PERIOD_DEF = 100;
  localparam int CURRENT_PERIOD_DEF  = 10;

  // Tick counter widths.
  localparam int POS_TICK_W = 10;
  localparam int VEL_TICK_W = 7;
  localparam int CUR_TICK_W = 4;

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Stream payload widths.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 112;

  // Shared multiplier operand widths.
  localparam int OP_A_W = 33;
  localparam int OP_B_W = 32;
  localparam int ACC_W  = 64;
  localparam int RAW_W  = 40;

  // Rounding shifts: Q2.30 angle gain and Q8.24 loop gains.
  localparam int ANGLE_SHIFT = 30;
  localparam int GAIN_SHIFT  = 24;

  // Floor division by 24.0 in Q16.16 is a shift by 19 and a division by three,
  // the latter done as a multiplication by a rounded-up reciprocal.
  localparam int PWM_SHIFT   = 19;
  localparam int RECIP_SHIFT = 21;
  localparam logic signed [OP_B_W-1:0] RECIP3 = 32'sd699051;

  localparam logic signed [OP_B_W-1:0] ANGLE_GAIN = 32'sd1332645699;
  localparam logic signed [OP_B_W-1:0] VEL_SCALE  = 32'sd2000;
  localparam logic [31:0]              ADC_STEP   = 32'd3200;
  localparam logic signed [31:0]       ADC_OFFSET = 32'sd1638400;

  localparam logic signed [OP_B_W-1:0] G_P_POS  = 32'sd36071014;
  localparam logic signed [OP_B_W-1:0] G_D_POS  = 32'sd2852127;
  localparam logic signed [OP_B_W-1:0] G_P_VEL  = 32'sd125829120;
  localparam logic signed [OP_B_W-1:0] G_I_VEL  = 32'sd8389;
  localparam logic signed [OP_B_W-1:0] G_KT     = 32'sd1145884;
  localparam logic signed [OP_B_W-1:0] G_KA_VEL = 32'sd2236962;
  localparam logic signed [OP_B_W-1:0] G_P_CUR  = 32'sd2207882;
  localparam logic signed [OP_B_W-1:0] G_I_CUR  = 32'sd2952790;
  localparam logic signed [OP_B_W-1:0] G_KA_CUR = 32'sd127486444;

  localparam logic signed [31:0] VEL_CLAMP = 32'sd42074112;
  localparam logic signed [31:0] CUR_CLAMP = 32'sd1572864;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_VLIM   = 2'd1,
    REG_CLIM   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ANG_MUL,
    ST_ANG_ACC,
    ST_ANG_WB,
    ST_VEL_MUL,
    ST_VEL_ACC,
    ST_VEL_WB,
    ST_POS_MUL_P,
    ST_POS_MUL_D,
    ST_POS_ACC,
    ST_POS_WB,
    ST_PI_ERR,
    ST_PI_KA,
    ST_PI_RND,
    ST_PI_INT,
    ST_PI_MUL_I,
    ST_PI_MUL_F,
    ST_PI_ACC,
    ST_PI_WB,
    ST_PWM_MUL,
    ST_PWM_ACC,
    ST_PWM_DIV,
    ST_PWM_DACC,
    ST_PWM_WB
  } state_e;

  // Rounded arithmetic right shift with halves going away from zero.
  // For a negative value, adding half minus one before the floor shift gives the same result.
  function automatic logic signed [RAW_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
                                                       input logic wide);
    logic signed [ACC_W-1:0] half;
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] s;
    half = wide ? (64'sd1 <<< (ANGLE_SHIFT - 1)) : (64'sd1 <<< (GAIN_SHIFT - 1));
    t    = v + half - ((v < 64'sd0) ? 64'sd1 : 64'sd0);
    s    = wide ? (t >>> ANGLE_SHIFT) : (t >>> GAIN_SHIFT);
    return s[RAW_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/cmpl_mac.sv
module cmpl_mac (
  input  logic                                clk_i,
  input  logic signed [cmpl_pkg::OP_A_W-1:0]  op_a_i,
  input  logic signed [cmpl_pkg::OP_B_W-1:0]  op_b_i,
  input  cmpl_pkg::acc_op_e                   acc_op_i,
  output logic signed [cmpl_pkg::ACC_W-1:0]   acc_o
);

  localparam int PROD_W = cmpl_pkg::OP_A_W + cmpl_pkg::OP_B_W;

  logic signed [PROD_W-1:0]          prod_w;
  logic signed [cmpl_pkg::ACC_W-1:0] prod_q;
  logic signed [cmpl_pkg::ACC_W-1:0] acc_q;
  logic signed [cmpl_pkg::ACC_W-1:0] acc_d;

  // The product is registered; the accumulator consumes it in the cycle after issue.
  assign prod_w = PROD_W'(op_a_i) * PROD_W'(op_b_i);

  always_comb begin
    unique case (acc_op_i)
      cmpl_pkg::ACC_LOAD: acc_d = prod_q;
      cmpl_pkg::ACC_ADD:  acc_d = acc_q + prod_q;
      default:            acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_w[cmpl_pkg::ACC_W-1:0];
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

>>> rtl/cascaded_motor_pid_loop_core.sv
// Cascaded position / velocity / current controller, one word per control tick.
// A word is taken only while idle; it passes the angle and velocity steps, any loop that
// fires (position, then velocity, then current) and the PWM step before the next is taken.
// One shared multiplier serves all these steps; the ADC scaling multiplies on its own.
// A finished result waits in an output register while the next word is accepted.
// Reset (asynchronous, active low) clears the config registers, loop state and tick counters.
module cascaded_motor_pid_loop_core #(
  parameter int PWM_MAX         = cmpl_pkg::PWM_MAX_DEF,
  parameter int PWM_MIN         = cmpl_pkg::PWM_MIN_DEF,
  parameter int POSITION_PERIOD = cmpl_pkg::POSITION_PERIOD_DEF,
  parameter int VELOCITY_PERIOD = cmpl_pkg::VELOCITY_PERIOD_DEF,
  parameter int CURRENT_PERIOD  = cmpl_pkg::CURRENT_PERIOD_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // encoder_count [31:0], adc_sample [41:32]
  input  logic [cmpl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pwm_compare [9:0], angle [41:10], velocity [73:42], motor_current [105:74]
  output logic [cmpl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cmpl_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cmpl_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cmpl_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int HALF = (PWM_MAX - PWM_MIN) / 2;
  localparam int MID  = PWM_MIN + HALF;

  // Configuration registers.
  logic signed [31:0] target_q;
  logic [30:0]        vlim_q;
  logic [30:0]        clim_q;
  logic               cfg_wr;
  logic               cfg_zero;

  // Sequencer.
  cmpl_pkg::state_e state_q, state_d;
  logic             pi_sel_q, pi_sel_d;  // 0: velocity loop, 1: current loop
  logic             s_ready;
  logic             done;
  logic             out_free;

  // Shared multiplier controls.
  logic signed [cmpl_pkg::OP_A_W-1:0] op_a;
  logic signed [cmpl_pkg::OP_B_W-1:0] op_b;
  cmpl_pkg::acc_op_e                  acc_op;
  logic signed [cmpl_pkg::ACC_W-1:0]  acc;

  // Per-word working registers.
  logic signed [31:0]                cnt_q;
  logic signed [31:0]                mc_q;
  logic signed [31:0]                angle_q;
  logic signed [31:0]                vel_q;
  logic signed [31:0]                perr_q;
  logic signed [31:0]                err_q;
  logic signed [cmpl_pkg::RAW_W-1:0] tmp_q;

  // Loop state.
  logic signed [31:0] prev_angle_q;
  logic signed [31:0] prev_perr_q;
  logic signed [31:0] pos_cmd_q;
  logic signed [31:0] vel_cmd_q;
  logic signed [31:0] cur_cmd_q;
  logic signed [31:0] vel_int_q;
  logic signed [31:0] vel_wind_q;
  logic signed [31:0] cur_int_q;
  logic signed [31:0] cur_wind_q;
  logic [cmpl_pkg::POS_TICK_W-1:0] pos_tick_q;
  logic [cmpl_pkg::VEL_TICK_W-1:0] vel_tick_q;
  logic [cmpl_pkg::CUR_TICK_W-1:0] cur_tick_q;
  logic fire_pos, fire_vel, fire_cur;

  // Output registers.
  logic               out_valid_q;
  logic [9:0]         out_pwm_q;
  logic signed [31:0] out_angle_q;
  logic signed [31:0] out_vel_q;
  logic signed [31:0] out_cur_q;

  // Derived values.
  logic signed [31:0]                mc_in;
  logic signed [31:0]                pi_cmd_in;
  logic [30:0]                       pi_lim;
  logic signed [31:0]                pi_meas;
  logic signed [31:0]                pi_int;
  logic signed [31:0]                pi_wind;
  logic signed [31:0]                pi_ff;
  logic signed [31:0]                pi_clamp;
  logic signed [32:0]                lim33;
  logic signed [32:0]                cmd33;
  logic signed [32:0]                cmd_clamped;
  logic signed [41:0]                int_sum;
  logic signed [31:0]                int_new;
  logic signed [cmpl_pkg::RAW_W-1:0] raw;
  logic signed [cmpl_pkg::RAW_W-1:0] raw_lim;
  logic signed [31:0]                pi_cmd_new;
  logic signed [31:0]                pi_wind_new;
  logic signed [19:0]                ocr;
  logic signed [19:0]                ocr_clamped;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign cfg_zero = (target_q == 32'sd0) && (vlim_q == 31'd0) && (clim_q == 31'd0);

  always_comb begin
    unique case (cmpl_pkg::cfg_reg_e'(paddr[3:2]))
      cmpl_pkg::REG_TARGET: prdata = target_q;
      cmpl_pkg::REG_VLIM:   prdata = {1'b0, vlim_q};
      cmpl_pkg::REG_CLIM:   prdata = {1'b0, clim_q};
      default:              prdata = '0;
    endcase
  end

  assign fire_pos = pos_tick_q >= cmpl_pkg::POS_TICK_W'(POSITION_PERIOD);
  assign fire_vel = vel_tick_q >= cmpl_pkg::VEL_TICK_W'(VELOCITY_PERIOD);
  assign fire_cur = cur_tick_q >= cmpl_pkg::CUR_TICK_W'(CURRENT_PERIOD);

  assign out_free = ~out_valid_q | m_axis_tready;

  assign mc_in = $signed(32'(s_axis_tdata[41:32]) * cmpl_pkg::ADC_STEP) - cmpl_pkg::ADC_OFFSET;

  // The velocity and current loops share one schedule; pi_sel_q picks the operands.
  assign pi_cmd_in = pi_sel_q ? vel_cmd_q  : pos_cmd_q;
  assign pi_lim    = pi_sel_q ? clim_q     : vlim_q;
  assign pi_meas   = pi_sel_q ? mc_q       : vel_q;
  assign pi_int    = pi_sel_q ? cur_int_q  : vel_int_q;
  assign pi_wind   = pi_sel_q ? cur_wind_q : vel_wind_q;
  assign pi_ff     = pi_sel_q ? vel_q      : mc_q;
  assign pi_clamp  = pi_sel_q ? cmpl_pkg::CUR_CLAMP : cmpl_pkg::VEL_CLAMP;

  assign lim33 = 33'($signed({1'b0, pi_lim}));
  assign cmd33 = 33'(pi_cmd_in);

  always_comb begin
    if (cmd33 > lim33) begin
      cmd_clamped = lim33;
    end else if (cmd33 < -lim33) begin
      cmd_clamped = -lim33;
    end else begin
      cmd_clamped = cmd33;
    end
  end

  assign int_sum = 42'(pi_int) + 42'(err_q) - 42'(tmp_q);

  always_comb begin
    if (int_sum > 42'(pi_clamp)) begin
      int_new = pi_clamp;
    end else if (int_sum < -42'(pi_clamp)) begin
      int_new = -pi_clamp;
    end else begin
      int_new = int_sum[31:0];
    end
  end

  // Loop output with saturation; the overshoot is kept for anti-windup.
  assign raw     = cmpl_pkg::rnd_shift(acc, 1'b0);
  assign raw_lim = cmpl_pkg::RAW_W'(pi_clamp);

  always_comb begin
    if (raw > raw_lim) begin
      pi_cmd_new  = pi_clamp;
      pi_wind_new = cmpl_pkg::sat32(64'(raw - raw_lim));
    end else if (raw < -raw_lim) begin
      pi_cmd_new  = -pi_clamp;
      pi_wind_new = cmpl_pkg::sat32(64'(raw + raw_lim));
    end else begin
      pi_cmd_new  = raw[31:0];
      pi_wind_new = 32'sd0;
    end
  end

  // The accumulator holds the reciprocal product; shifting it out gives the quotient by three.
  assign ocr = 20'(acc >>> cmpl_pkg::RECIP_SHIFT) - 20'(HALF) + 20'(MID);

  always_comb begin
    priority if (cfg_zero) begin
      ocr_clamped = 20'(MID);
    end else if (ocr > 20'(PWM_MAX)) begin
      ocr_clamped = 20'(PWM_MAX);
    end else if (ocr < 20'(PWM_MIN)) begin
      ocr_clamped = 20'(PWM_MIN);
    end else begin
      ocr_clamped = ocr;
    end
  end

  cmpl_mac u_mac (
    .clk_i    (clk_i),
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .acc_op_i (acc_op),
    .acc_o    (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cmpl_pkg::ST_IDLE;
      pi_sel_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pi_sel_q <= pi_sel_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    pi_sel_d = pi_sel_q;
    op_a     = '0;
    op_b     = '0;
    acc_op   = cmpl_pkg::ACC_HOLD;
    s_ready  = 1'b0;
    done     = 1'b0;
    unique case (state_q)
      cmpl_pkg::ST_IDLE: begin
        s_ready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = cmpl_pkg::ST_ANG_MUL;
        end
      end
      cmpl_pkg::ST_ANG_MUL: begin
        op_a    = cmpl_pkg::OP_A_W'(cnt_q);
        op_b    = cmpl_pkg::ANGLE_GAIN;
        state_d = cmpl_pkg::ST_ANG_ACC;
      end
      cmpl_pkg::ST_ANG_ACC: begin
        acc_op  = cmpl_pkg::ACC_LOAD;
        state_d = cmpl_pkg::ST_ANG_WB;
      end
      cmpl_pkg::ST_ANG_WB: begin
        state_d = cmpl_pkg::ST_VEL_MUL;
      end
      cmpl_pkg::ST_VEL_MUL: begin
        op_a    = cmpl_pkg::OP_A_W'(angle_q) - cmpl_pkg::OP_A_W'(prev_angle_q);
        op_b    = cmpl_pkg::VEL_SCALE;
        state_d = cmpl_pkg::ST_VEL_ACC;
      end
      cmpl_pkg::ST_VEL_ACC: begin
        acc_op  = cmpl_pkg::ACC_LOAD;
        state_d = cmpl_pkg::ST_VEL_WB;
      end
      cmpl_pkg::ST_VEL_WB: begin
        priority if (fire_pos) begin
          state_d = cmpl_pkg::ST_POS_MUL_P;
        end else if (fire_vel) begin
          state_d  = cmpl_pkg::ST_PI_ERR;
          pi_sel_d = 1'b0;
        end else if (fire_cur) begin
          state_d  = cmpl_pkg::ST_PI_ERR;
          pi_sel_d = 1'b1;
        end else begin
          state_d = cmpl_pkg::ST_PWM_MUL;
        end
      end
      cmpl_pkg::ST_POS_MUL_P: begin
        op_a    = cmpl_pkg::OP_A_W'(perr_q);
        op_b    = cmpl_pkg::G_P_POS;
        state_d = cmpl_pkg::ST_POS_MUL_D;
      end
      cmpl_pkg::ST_POS_MUL_D: begin
        op_a    = cmpl_pkg::OP_A_W'(err_q);
        op_b    = cmpl_pkg::G_D_POS;
        acc_op  = cmpl_pkg::ACC_LOAD;
        state_d = cmpl_pkg::ST_POS_ACC;
      end
      cmpl_pkg::ST_POS_ACC: begin
        acc_op  = cmpl_pkg::ACC_ADD;
        state_d = cmpl_pkg::ST_POS_WB;
      end
      cmpl_pkg::ST_POS_WB: begin
        priority if (fire_vel) begin
          state_d  = cmpl_pkg::ST_PI_ERR;
          pi_sel_d = 1'b0;
        end else if (fire_cur) begin
          state_d  = cmpl_pkg::ST_PI_ERR;
          pi_sel_d = 1'b1;
        end else begin
          state_d = cmpl_pkg::ST_PWM_MUL;
        end
      end
      cmpl_pkg::ST_PI_ERR: begin
        op_a    = cmpl_pkg::OP_A_W'(pi_wind);
        op_b    = pi_sel_q ? cmpl_pkg::G_KA_CUR : cmpl_pkg::G_KA_VEL;
        state_d = cmpl_pkg::ST_PI_KA;
      end
      cmpl_pkg::ST_PI_KA: begin
        acc_op  = cmpl_pkg::ACC_LOAD;
        state_d = cmpl_pkg::ST_PI_RND;
      end
      cmpl_pkg::ST_PI_RND: begin
        state_d = cmpl_pkg::ST_PI_INT;
      end
      cmpl_pkg::ST_PI_INT: begin
        op_a    = cmpl_pkg::OP_A_W'(err_q);
        op_b    = pi_sel_q ? cmpl_pkg::G_P_CUR : cmpl_pkg::G_P_VEL;
        state_d = cmpl_pkg::ST_PI_MUL_I;
      end
      cmpl_pkg::ST_PI_MUL_I: begin
        op_a    = cmpl_pkg::OP_A_W'(pi_int);
        op_b    = pi_sel_q ? cmpl_pkg::G_I_CUR : cmpl_pkg::G_I_VEL;
        acc_op  = cmpl_pkg::ACC_LOAD;
        state_d = cmpl_pkg::ST_PI_MUL_F;
      end
      cmpl_pkg::ST_PI_MUL_F: begin
        op_a    = cmpl_pkg::OP_A_W'(pi_ff);
        op_b    = cmpl_pkg::G_KT;
        acc_op  = cmpl_pkg::ACC_ADD;
        state_d = cmpl_pkg::ST_PI_ACC;
      end
      cmpl_pkg::ST_PI_ACC: begin
        acc_op  = cmpl_pkg::ACC_ADD;
        state_d = cmpl_pkg::ST_PI_WB;
      end
      cmpl_pkg::ST_PI_WB: begin
        if (!pi_sel_q && fire_cur) begin
          state_d  = cmpl_pkg::ST_PI_ERR;
          pi_sel_d = 1'b1;
        end else begin
          state_d = cmpl_pkg::ST_PWM_MUL;
        end
      end
      cmpl_pkg::ST_PWM_MUL: begin
        op_a    = cmpl_pkg::OP_A_W'(cur_cmd_q);
        op_b    = cmpl_pkg::OP_B_W'(HALF);
        state_d = cmpl_pkg::ST_PWM_ACC;
      end
      cmpl_pkg::ST_PWM_ACC: begin
        acc_op  = cmpl_pkg::ACC_LOAD;
        state_d = cmpl_pkg::ST_PWM_DIV;
      end
      cmpl_pkg::ST_PWM_DIV: begin
        // Offset by three halves so the dividend is never negative.
        op_a    = cmpl_pkg::OP_A_W'(acc >>> cmpl_pkg::PWM_SHIFT) + cmpl_pkg::OP_A_W'(3 * HALF);
        op_b    = cmpl_pkg::RECIP3;
        state_d = cmpl_pkg::ST_PWM_DACC;
      end
      cmpl_pkg::ST_PWM_DACC: begin
        acc_op  = cmpl_pkg::ACC_LOAD;
        state_d = cmpl_pkg::ST_PWM_WB;
      end
      cmpl_pkg::ST_PWM_WB: begin
        if (out_free) begin
          done    = 1'b1;
          state_d = cmpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cmpl_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration, loop state and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      vlim_q       <= '0;
      clim_q       <= '0;
      prev_angle_q <= '0;
      prev_perr_q  <= '0;
      pos_cmd_q    <= '0;
      vel_cmd_q    <= '0;
      cur_cmd_q    <= '0;
      vel_int_q    <= '0;
      vel_wind_q   <= '0;
      cur_int_q    <= '0;
      cur_wind_q   <= '0;
      pos_tick_q   <= '0;
      vel_tick_q   <= '0;
      cur_tick_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cmpl_pkg::cfg_reg_e'(paddr[3:2]))
          cmpl_pkg::REG_TARGET: target_q <= $signed(pwdata);
          cmpl_pkg::REG_VLIM:   vlim_q   <= pwdata[30:0];
          cmpl_pkg::REG_CLIM:   clim_q   <= pwdata[30:0];
          default: ;
        endcase
      end
      if (state_q == cmpl_pkg::ST_POS_WB) begin
        pos_cmd_q <= cmpl_pkg::sat32(64'(raw));
      end
      if (state_q == cmpl_pkg::ST_PI_INT) begin
        if (pi_sel_q) begin
          cur_int_q <= int_new;
        end else begin
          vel_int_q <= int_new;
        end
      end
      if (state_q == cmpl_pkg::ST_PI_WB) begin
        if (pi_sel_q) begin
          cur_cmd_q  <= pi_cmd_new;
          cur_wind_q <= pi_wind_new;
        end else begin
          vel_cmd_q  <= pi_cmd_new;
          vel_wind_q <= pi_wind_new;
        end
      end
      if (done) begin
        prev_angle_q <= angle_q;
        prev_perr_q  <= perr_q;
        pos_tick_q   <= fire_pos ? cmpl_pkg::POS_TICK_W'(1)
                                 : pos_tick_q + cmpl_pkg::POS_TICK_W'(1);
        vel_tick_q   <= fire_vel ? cmpl_pkg::VEL_TICK_W'(1)
                                 : vel_tick_q + cmpl_pkg::VEL_TICK_W'(1);
        cur_tick_q   <= fire_cur ? cmpl_pkg::CUR_TICK_W'(1)
                                 : cur_tick_q + cmpl_pkg::CUR_TICK_W'(1);
      end
      out_valid_q <= done | (out_valid_q & ~m_axis_tready);
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_ready) begin
      cnt_q <= $signed(s_axis_tdata[31:0]);
      mc_q  <= mc_in;
    end
    unique case (state_q)
      cmpl_pkg::ST_ANG_WB:    angle_q <= cmpl_pkg::sat32(64'(cmpl_pkg::rnd_shift(acc, 1'b1)));
      cmpl_pkg::ST_VEL_MUL:   perr_q  <= cmpl_pkg::sat32(64'(target_q) - 64'(angle_q));
      cmpl_pkg::ST_VEL_WB:    vel_q   <= cmpl_pkg::sat32(acc);
      cmpl_pkg::ST_POS_MUL_P: err_q   <= cmpl_pkg::sat32(64'(perr_q) - 64'(prev_perr_q));
      cmpl_pkg::ST_PI_ERR:    err_q   <= cmpl_pkg::sat32(64'(cmd_clamped) - 64'(pi_meas));
      cmpl_pkg::ST_PI_RND:    tmp_q   <= raw;
      default: ;
    endcase
    if (done) begin
      out_pwm_q   <= ocr_clamped[9:0];
      out_angle_q <= angle_q;
      out_vel_q   <= vel_q;
      out_cur_q   <= mc_q;
    end
  end

  assign s_axis_tready = s_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_cur_q, out_vel_q, out_angle_q, out_pwm_q};

endmodule

>>> dv/testbench.sv
module testbench;

  // Build-time settings of the block under test.
  localparam int PWM_TOP       = 800;
  localparam int PWM_BOTTOM    = 0;
  localparam int POS_PERIOD    = 1000;
  localparam int VEL_PERIOD    = 100;
  localparam int CUR_PERIOD    = 10;
  localparam int POS_TICK_MASK = 'h3FF;
  localparam int VEL_TICK_MASK = 'h7F;
  localparam int CUR_TICK_MASK = 'hF;

  // Fixed-point constants: signals Q16.16, loop gains Q8.24, angle gain Q2.30.
  localparam int     ANGLE_Q        = 30;
  localparam int     GAIN_Q         = 24;
  localparam longint ANGLE_GAIN_Q30 = 64'sd1332645699;
  localparam longint RATE_SCALE     = 64'sd2000;
  localparam longint AMPS_PER_LSB   = 64'sd3200;
  localparam longint AMPS_OFFSET    = 64'sd1638400;
  localparam longint K_POS_P        = 64'sd36071014;
  localparam longint K_POS_D        = 64'sd2852127;
  localparam longint K_VEL_P        = 64'sd125829120;
  localparam longint K_VEL_I        = 64'sd8389;
  localparam longint K_TORQUE       = 64'sd1145884;
  localparam longint K_VEL_AW       = 64'sd2236962;
  localparam longint K_CUR_P        = 64'sd2207882;
  localparam longint K_CUR_I        = 64'sd2952790;
  localparam longint K_CUR_AW       = 64'sd127486444;
  localparam longint VEL_CLAMP_Q16  = 64'sd642 * 64'sd65536;
  localparam longint CUR_CLAMP_Q16  = 64'sd24 * 64'sd65536;
  localparam longint S32_MAX        = 64'sd2147483647;
  localparam longint S32_MIN        = -64'sd2147483648;
  localparam longint PWM_HALF       = (PWM_TOP - PWM_BOTTOM) / 2;
  localparam longint PWM_MID        = PWM_BOTTOM + PWM_HALF;
  localparam longint PWM_DEN        = 64'sd24 * 64'sd65536;

  // Address with no register behind it (index 3).
  localparam logic [cmpl_pkg::APB_ADDR_W-1:0] SPARE_ADDR = 4'd12;

  localparam int RESET_CYCLES   = 10;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTED    = 100;

  typedef struct {
    logic [9:0]  pwm;
    logic [31:0] angle;
    logic [31:0] velocity;
    logic [31:0] current;
  } tick_result_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // encoder_count [31:0], adc_sample [41:32]
  logic [cmpl_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b1;
  // pwm_compare [9:0], angle [41:10], velocity [73:42], motor_current [105:74]
  logic [cmpl_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            psel          = 1'b0;
  logic                            penable       = 1'b0;
  logic                            pwrite        = 1'b0;
  logic [cmpl_pkg::APB_ADDR_W-1:0] paddr         = '0;
  logic [cmpl_pkg::APB_DATA_W-1:0] pwdata        = '0;
  logic [cmpl_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  // Controller shadow: configuration, loop state and tick counters.
  longint tgt_pos = 0, vel_lim = 0, cur_lim = 0;
  longint prev_angle = 0, prev_pos_err = 0, pos_cmd = 0, vel_cmd = 0, cur_cmd = 0;
  longint vel_int = 0, vel_excess = 0, cur_int = 0, cur_excess = 0;
  int     pos_ticks = 0, vel_ticks = 0, cur_ticks = 0;

  tick_result_t        pending_ticks[$];
  int                  mismatch_count = 0;
  int                  stall_cycles   = 0;
  int                  src_idle_pct   = 0;
  int                  snk_stall_pct  = 0;
  logic signed [31:0]  path_count     = '0;
  int                  path_step      = 0;

  cascaded_motor_pid_loop_core #(
    .PWM_MAX        (PWM_TOP),
    .PWM_MIN        (PWM_BOTTOM),
    .POSITION_PERIOD(POS_PERIOD),
    .VELOCITY_PERIOD(VEL_PERIOD),
    .CURRENT_PERIOD (CUR_PERIOD)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint clip32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint clip_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Halves round away from zero.
  function automatic longint round_shift(longint v, int sh);
    longint half;
    half = 64'sd1 <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint limit_output(longint raw, longint lim, output longint excess);
    if (raw > lim) begin
      excess = clip32(raw - lim);
      return lim;
    end
    if (raw < -lim) begin
      excess = clip32(raw + lim);
      return -lim;
    end
    excess = 0;
    return raw;
  endfunction

  // Runs one control tick on the shadow state and returns the word it should produce.
  function automatic tick_result_t predict_tick(logic signed [31:0] count, logic [9:0] adc);
    tick_result_t r;
    longint ang, vel, amps, perr, err, acc, n, q, ocr;
    ang  = clip32(round_shift(longint'(count) * ANGLE_GAIN_Q30, ANGLE_Q));
    vel  = clip32((ang - prev_angle) * RATE_SCALE);
    amps = longint'(adc) * AMPS_PER_LSB - AMPS_OFFSET;
    perr = clip32(tgt_pos - ang);

    if (pos_ticks >= POS_PERIOD) begin
      pos_ticks = 0;
      acc = K_POS_P * perr + K_POS_D * clip32(perr - prev_pos_err);
      pos_cmd = clip32(round_shift(acc, GAIN_Q));
    end

    if (vel_ticks >= VEL_PERIOD) begin
      vel_ticks = 0;
      err = clip32(clip_sym(pos_cmd, vel_lim) - vel);
      acc = vel_int + err - round_shift(K_VEL_AW * vel_excess, GAIN_Q);
      vel_int = clip_sym(acc, VEL_CLAMP_Q16);
      acc = K_VEL_P * err + K_VEL_I * vel_int + K_TORQUE * amps;
      vel_cmd = limit_output(round_shift(acc, GAIN_Q), VEL_CLAMP_Q16, vel_excess);
    end

    if (cur_ticks >= CUR_PERIOD) begin
      cur_ticks = 0;
      err = clip32(clip_sym(vel_cmd, cur_lim) - amps);
      acc = cur_int + err - round_shift(K_CUR_AW * cur_excess, GAIN_Q);
      cur_int = clip_sym(acc, CUR_CLAMP_Q16);
      acc = K_CUR_P * err + K_CUR_I * cur_int + K_TORQUE * vel;
      cur_cmd = limit_output(round_shift(acc, GAIN_Q), CUR_CLAMP_Q16, cur_excess);
    end

    // With every register cleared the output parks at the midpoint.
    if (tgt_pos == 0 && vel_lim == 0 && cur_lim == 0) begin
      ocr = PWM_MID;
    end else begin
      n = cur_cmd * PWM_HALF;
      q = n / PWM_DEN;
      if (n % PWM_DEN != 0 && n < 0) q = q - 1;
      ocr = PWM_MID + q;
    end
    if (ocr > PWM_TOP) ocr = PWM_TOP;
    else if (ocr < PWM_BOTTOM) ocr = PWM_BOTTOM;

    prev_pos_err = perr;
    prev_angle   = ang;
    pos_ticks    = (pos_ticks + 1) & POS_TICK_MASK;
    vel_ticks    = (vel_ticks + 1) & VEL_TICK_MASK;
    cur_ticks    = (cur_ticks + 1) & CUR_TICK_MASK;

    r.pwm      = ocr[9:0];
    r.angle    = ang[31:0];
    r.velocity = vel[31:0];
    r.current  = amps[31:0];
    return r;
  endfunction

  function automatic logic [cmpl_pkg::APB_ADDR_W-1:0] reg_addr(cmpl_pkg::cfg_reg_e r);
    return {r, 2'b00};
  endfunction

  function automatic logic [31:0] reg_value(cmpl_pkg::cfg_reg_e r);
    unique case (r)
      cmpl_pkg::REG_TARGET: return tgt_pos[31:0];
      cmpl_pkg::REG_VLIM:   return {1'b0, vel_lim[30:0]};
      default:              return {1'b0, cur_lim[30:0]};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatch_count < MAX_PRINTED) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
    mismatch_count++;
  endtask

  task automatic check_word(input logic [cmpl_pkg::OUT_DATA_W-1:0] word);
    tick_result_t want;
    if (pending_ticks.size() == 0) begin
      report_mismatch("word with nothing pending", '0, {22'b0, word[9:0]});
      return;
    end
    want = pending_ticks.pop_front();
    if (word[9:0] !== want.pwm) report_mismatch("pwm_compare", {22'b0, want.pwm},
                                                  {22'b0, word[9:0]});
    if (word[41:10] !== want.angle) report_mismatch("angle", want.angle, word[41:10]);
    if (word[73:42] !== want.velocity) report_mismatch("velocity", want.velocity,
                                                       word[73:42]);
    if (word[105:74] !== want.current) report_mismatch("motor_current", want.current,
                                                       word[105:74]);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Ends the run when neither stream nor the register port has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_tick(input logic signed [31:0] count, input logic [9:0] adc);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, adc, count};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_ticks.push_back(predict_tick(count, adc));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cmpl_pkg::APB_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == reg_addr(cmpl_pkg::REG_TARGET)) tgt_pos = longint'(signed'(data));
    else if (addr == reg_addr(cmpl_pkg::REG_VLIM)) vel_lim = longint'(data[30:0]);
    else if (addr == reg_addr(cmpl_pkg::REG_CLIM)) cur_lim = longint'(data[30:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_reg(input cmpl_pkg::cfg_reg_e r);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(r);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== reg_value(r)) report_mismatch(r.name(), reg_value(r), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [31:0] target, input logic [31:0] vlim,
                                input logic [31:0] clim);
    drain_results();
    write_reg(reg_addr(cmpl_pkg::REG_TARGET), target);
    write_reg(reg_addr(cmpl_pkg::REG_VLIM), vlim);
    write_reg(reg_addr(cmpl_pkg::REG_CLIM), clim);
    read_reg(cmpl_pkg::REG_TARGET);
    read_reg(cmpl_pkg::REG_VLIM);
    read_reg(cmpl_pkg::REG_CLIM);
  endtask

  // Mostly smooth encoder trajectories with the current near zero, so that the loops work
  // in their linear range; the rest is full-range noise and field extremes.
  task automatic make_tick(output logic signed [31:0] count, output logic [9:0] adc);
    int pick;
    int jitter;
    pick = $urandom_range(99);
    if (pick < 80) begin
      if ($urandom_range(49) == 0) path_count = $urandom;
      if ($urandom_range(19) == 0) path_step = int'($urandom_range(400)) - 200;
      jitter = int'($urandom_range(6)) - 3;
      path_count = path_count + path_step + jitter;
      count = path_count;
      adc = 10'(472 + $urandom_range(80));
    end else if (pick < 95) begin
      count = $urandom;
      adc = 10'($urandom_range(1023));
    end else begin
      case ($urandom_range(3))
        0:       count = 32'sh7fffffff;
        1:       count = 32'sh80000000;
        2:       count = '0;
        default: count = '1;
      endcase
      adc = $urandom_range(1) ? 10'h3FF : 10'h000;
    end
  endtask

  task automatic run_traffic(input int src_pct, input int snk_pct, input int items);
    logic signed [31:0] count;
    logic [9:0]         adc;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < items; i++) begin
      // Let the pipeline run dry once in the middle of every phase.
      if (i == items / 2) drain_results();
      make_tick(count, adc);
      send_tick(count, adc);
    end
  endtask

  // Registers at reset keep the output at the midpoint while the current loop fires.
  task automatic test_settings_zero();
    logic [31:0] counts [0:10];
    logic [9:0]  adcs   [0:10];
    counts = '{32'h0, 32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
               32'h7FFFFFFF, 32'h80000000, 32'h2AAAAAAA, 32'h55555555, 32'h0};
    adcs   = '{10'h000, 10'h3FF, 10'h200, 10'h200, 10'h000, 10'h3FF,
               10'h3FF, 10'h000, 10'h155, 10'h2AA, 10'h200};
    read_reg(cmpl_pkg::REG_TARGET);
    read_reg(cmpl_pkg::REG_VLIM);
    read_reg(cmpl_pkg::REG_CLIM);
    for (int i = 0; i <= 10; i++) send_tick(counts[i], adcs[i]);
  endtask

  // Bits above a register's width are dropped, and the spare address changes nothing.
  task automatic test_register_access();
    apply_settings(32'h80000000, 32'hFFFFFFFF, 32'h80000001);
    write_reg(SPARE_ADDR, 32'hFFFFFFFF);
    read_reg(cmpl_pkg::REG_TARGET);
    read_reg(cmpl_pkg::REG_VLIM);
    read_reg(cmpl_pkg::REG_CLIM);
  endtask

  // Saturating measurements and currents that drive the current loop into its clamp.
  task automatic test_loop_extremes();
    logic [31:0] counts [0:11];
    logic [9:0]  adcs   [0:11];
    counts = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h1,
               32'h80000000, 32'h40000000, 32'hC0000000, 32'h00010000, 32'h00010000,
               32'hFFFF0000};
    adcs   = '{10'h3FF, 10'h000, 10'h3FF, 10'h000, 10'h3FF, 10'h000,
               10'h3FF, 10'h200, 10'h000, 10'h3FF, 10'h000, 10'h200};
    apply_settings(32'h00010000, 32'h7FFFFFFF, 32'h00050000);
    for (int i = 0; i <= 11; i++) send_tick(counts[i], adcs[i]);
  endtask

  task automatic test_steady_stream();
    apply_settings(32'h00032000, 32'h00050000, 32'h00030000);
    run_traffic(0, 0, 265);
  endtask

  task automatic test_source_gaps();
    apply_settings(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    run_traffic(47, 0, 265);
  endtask

  task automatic test_sink_backpressure();
    apply_settings(32'h80000000, 32'h00000000, 32'h00000001);
    run_traffic(0, 47, 265);
  endtask

  // The position loop fires for the first time during this phase.
  task automatic test_two_sided_idling();
    apply_settings(32'hFFFE0000, 32'h00640000, 32'h00180000);
    run_traffic(27, 27, 265);
  endtask

  task automatic test_settings_cleared();
    apply_settings(32'h0, 32'h0, 32'h0);
    run_traffic(0, 0, 265);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_settings_zero();
    test_register_access();
    test_loop_extremes();
    test_steady_stream();
    test_source_gaps();
    test_sink_backpressure();
    test_two_sided_idling();
    test_settings_cleared();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_ticks.size() != 0) begin
      report_mismatch("words never produced", '0, pending_ticks.size());
    end
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cmpl_pkg.sv
rtl/cmpl_mac.sv
rtl/cascaded_motor_pid_loop_core.sv
dv/testbench.sv
